// ===== src/fpd_pkg.sv =====
// Package for the flight phase detector: item types, phase codes, register map.
// No dependencies.
package fpd_pkg;

    typedef enum logic [2:0] {
        PH_UNARMED = 3'd0,
        PH_ARMED   = 3'd1,
        PH_LAUNCH  = 3'd2,
        PH_APOGEE  = 3'd3,
        PH_DESCENT = 3'd4,
        PH_LANDED  = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    localparam logic [2:0] PH_CODE_UNUSED = 3'd7;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    localparam logic [2:0] REG_LAUNCH_ACC  = 3'd0;
    localparam logic [2:0] REG_LAUNCH_HOLD = 3'd1;
    localparam logic [2:0] REG_APOGEE_VEL  = 3'd2;
    localparam logic [2:0] REG_APOGEE_HOLD = 3'd3;
    localparam logic [2:0] REG_LANDED_ALT  = 3'd4;
    localparam logic [2:0] REG_LANDED_ACC  = 3'd5;
    localparam logic [2:0] REG_LANDED_HOLD = 3'd6;

    localparam int DIV_BITS  = 42;
    localparam int PROD_BITS = DIV_BITS + 1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        time_ms;
        logic signed [31:0] altitude;
        logic signed [15:0] acceleration;
        logic signed [31:0] velocity;
        logic [2:0]         new_phase;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         phase;
        logic               state_changed;
        logic signed [31:0] max_altitude;
        logic signed [31:0] velocity_used;
        logic [31:0]        launch_time;
        logic [31:0]        apogee_time;
        logic [31:0]        landed_time;
        logic               logging_on;
        logic               radio_on;
        logic               error_flag;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FSM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [31:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/flight_phase_detector_top.sv =====
// Flight phase detector: takes timestamped sensor and command items and returns
// one result item each, with an APB register port. Depends on fpd_pkg, fpd_divider.
//
// The block takes one item at a time. Command items and samples with a given
// velocity pass through the multiply, phase and output states; a sample with zero
// velocity and nonzero elapsed time also derives velocity in the divide state through
// a bit-serial divider (42 quotient bits, one per cycle). A result waits in the
// output register until taken; meanwhile the next item is accepted and worked on,
// and it holds in its last stage until the output register is free.
module flight_phase_detector_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fpd_pkg::t_in_item     i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fpd_pkg::t_out_item    o_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import fpd_pkg::*;

    logic signed [15:0] r_launch_acc;
    logic [15:0]        r_launch_hold;
    logic signed [31:0] r_apogee_vel;
    logic [15:0]        r_apogee_hold;
    logic signed [31:0] r_landed_alt;
    logic [14:0]        r_landed_acc;
    logic [15:0]        r_landed_hold;

    t_state             r_state, n_state;
    t_in_item           r_in;
    t_phase             r_phase, n_phase;
    logic signed [31:0] r_max_alt, n_max_alt;
    logic signed [31:0] r_prev_alt, n_prev_alt;
    logic [31:0]        r_last_time, n_last_time;
    logic [31:0]        r_hold_start [3];
    logic [31:0]        n_hold_start [3];
    logic [2:0]         r_hold_act, n_hold_act;
    logic [31:0]        r_evt [3];
    logic [31:0]        n_evt [3];
    logic               r_log, n_log, r_radio, n_radio, r_err, n_err;
    logic [31:0]        r_dt, n_dt;
    logic signed [PROD_BITS-1:0] r_prod, n_prod;
    logic signed [31:0] r_vel, n_vel;
    logic               r_neg, n_neg;
    logic               r_changed, n_changed;
    logic               r_ovalid, n_ovalid;
    t_out_item          r_out, n_out;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               wr_en;
    logic signed [32:0] alt_diff;
    logic [DIV_BITS-1:0] abs_prod;
    logic signed [PROD_BITS-1:0] sq;
    logic signed [16:0] acc_dev;
    logic [16:0]        acc_abs;
    logic               cond, fire;
    logic [1:0]         hidx;
    logic [31:0]        hold_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_acc  <= 16'sd512;
            r_launch_hold <= 16'd100;
            r_apogee_vel  <= '0;
            r_apogee_hold <= 16'd100;
            r_landed_alt  <= 32'sd7680;
            r_landed_acc  <= 15'd51;
            r_landed_hold <= 16'd2000;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_LAUNCH_ACC:  r_launch_acc  <= pwdata[15:0];
                REG_LAUNCH_HOLD: r_launch_hold <= pwdata[15:0];
                REG_APOGEE_VEL:  r_apogee_vel  <= pwdata;
                REG_APOGEE_HOLD: r_apogee_hold <= pwdata[15:0];
                REG_LANDED_ALT:  r_landed_alt  <= pwdata;
                REG_LANDED_ACC:  r_landed_acc  <= pwdata[14:0];
                REG_LANDED_HOLD: r_landed_hold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LAUNCH_ACC:  prdata = {16'd0, r_launch_acc};
            REG_LAUNCH_HOLD: prdata = {16'd0, r_launch_hold};
            REG_APOGEE_VEL:  prdata = r_apogee_vel;
            REG_APOGEE_HOLD: prdata = {16'd0, r_apogee_hold};
            REG_LANDED_ALT:  prdata = r_landed_alt;
            REG_LANDED_ACC:  prdata = {17'd0, r_landed_acc};
            REG_LANDED_HOLD: prdata = {16'd0, r_landed_hold};
            default:         prdata = '0;
        endcase
    end

    fpd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_UNARMED;
            r_max_alt   <= '0;
            r_prev_alt  <= '0;
            r_last_time <= '0;
            r_hold_act  <= '0;
            r_log       <= 1'b0;
            r_radio     <= 1'b0;
            r_err       <= 1'b0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_hold_start[i] <= '0;
                r_evt[i]        <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_max_alt   <= n_max_alt;
            r_prev_alt  <= n_prev_alt;
            r_last_time <= n_last_time;
            r_hold_act  <= n_hold_act;
            r_log       <= n_log;
            r_radio     <= n_radio;
            r_err       <= n_err;
            r_ovalid    <= n_ovalid;
            for (int i = 0; i < 3; i++) begin
                r_hold_start[i] <= n_hold_start[i];
                r_evt[i]        <= n_evt[i];
            end
        end
        if (o_ready && i_valid)
            r_in <= i_item;
        r_dt      <= n_dt;
        r_prod    <= n_prod;
        r_vel     <= n_vel;
        r_neg     <= n_neg;
        r_changed <= n_changed;
        r_out     <= n_out;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_max_alt   = r_max_alt;
        n_prev_alt  = r_prev_alt;
        n_last_time = r_last_time;
        n_hold_act  = r_hold_act;
        n_log       = r_log;
        n_radio     = r_radio;
        n_err       = r_err;
        n_ovalid    = r_ovalid && !i_ready;
        n_hold_start = r_hold_start;
        n_evt       = r_evt;
        n_dt        = r_dt;
        n_prod      = r_prod;
        n_vel       = r_vel;
        n_neg       = r_neg;
        n_changed   = r_changed;
        n_out       = r_out;
        div_req     = '0;
        alt_diff    = 33'(r_in.altitude) - 33'(r_prev_alt);
        abs_prod    = r_prod[PROD_BITS-1] ? DIV_BITS'(-r_prod) : DIV_BITS'(r_prod);
        sq          = r_neg ? -PROD_BITS'(div_rsp.quotient) : PROD_BITS'(div_rsp.quotient);
        acc_dev     = 17'(r_in.acceleration) - 17'sd256;
        acc_abs     = acc_dev[16] ? 17'(-acc_dev) : 17'(acc_dev);
        cond        = 1'b0;
        hidx        = 2'd0;
        hold_val    = '0;
        fire        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready)
                    n_state = ST_MUL;
            end
            ST_MUL: begin
                n_changed = 1'b0;
                n_vel     = '0;
                if (r_in.kind == KIND_SAMPLE) begin
                    n_dt        = r_in.time_ms - r_last_time;
                    n_last_time = r_in.time_ms;
                    if (r_in.altitude > r_max_alt)
                        n_max_alt = r_in.altitude;
                    n_prod = PROD_BITS'(alt_diff) * PROD_BITS'(12'sd1000);
                    n_vel  = r_in.velocity;
                    if (r_in.velocity == 0 && n_dt != 0)
                        n_state = ST_DIV;
                    else
                        n_state = ST_FSM;
                end else begin
                    n_state = ST_FSM;
                end
            end
            ST_DIV: begin
                if (r_vel == 0) begin
                    n_neg            = r_prod[PROD_BITS-1];
                    div_req.start    = 1'b1;
                    div_req.dividend = abs_prod;
                    div_req.divisor  = r_dt;
                    n_vel            = 32'sd1;
                end else if (div_rsp.done) begin
                    if (sq > PROD_BITS'(32'sh7FFFFFFF))
                        n_vel = 32'sh7FFFFFFF;
                    else if (sq < PROD_BITS'(32'sh80000000))
                        n_vel = 32'sh80000000;
                    else
                        n_vel = 32'(sq);
                    n_state = ST_FSM;
                end
            end
            ST_FSM: begin
                if (r_in.kind == KIND_SAMPLE) begin
                    n_prev_alt = r_in.altitude;
                    case (r_phase)
                        PH_ARMED: begin
                            hidx = 2'd0;
                            cond = r_in.acceleration > r_launch_acc;
                            hold_val = {16'd0, r_launch_hold};
                        end
                        PH_LAUNCH: begin
                            hidx = 2'd1;
                            cond = r_vel < r_apogee_vel;
                            hold_val = {16'd0, r_apogee_hold};
                        end
                        PH_DESCENT: begin
                            hidx = 2'd2;
                            cond = (r_in.altitude < r_landed_alt) &&
                                   (acc_abs < {2'd0, r_landed_acc});
                            hold_val = {16'd0, r_landed_hold};
                        end
                        default: ;
                    endcase
                    if (r_phase == PH_ARMED || r_phase == PH_LAUNCH ||
                            r_phase == PH_DESCENT) begin
                        if (!cond) begin
                            n_hold_act[hidx] = 1'b0;
                        end else if (!r_hold_act[hidx]) begin
                            n_hold_act[hidx]   = 1'b1;
                            n_hold_start[hidx] = r_in.time_ms;
                        end else if (r_in.time_ms - r_hold_start[hidx] >= hold_val) begin
                            n_hold_act[hidx] = 1'b0;
                            fire = 1'b1;
                        end
                        if (fire) begin
                            n_evt[hidx] = r_in.time_ms;
                            n_changed   = 1'b1;
                            case (r_phase)
                                PH_ARMED:  n_phase = PH_LAUNCH;
                                PH_LAUNCH: n_phase = PH_APOGEE;
                                default:   n_phase = PH_LANDED;
                            endcase
                        end
                    end else if (r_phase == PH_APOGEE && r_vel < -32'sd256) begin
                        n_phase   = PH_DESCENT;
                        n_changed = 1'b1;
                    end
                end else if (r_in.kind == KIND_SET) begin
                    if (r_in.new_phase <= 3'(PH_ERROR)) begin
                        n_phase = t_phase'(r_in.new_phase);
                        if (r_in.new_phase == 3'(PH_ARMED)) begin
                            n_log = 1'b1;
                            n_radio = 1'b1;
                        end else if (r_in.new_phase == 3'(PH_UNARMED)) begin
                            n_log = 1'b0;
                            n_radio = 1'b0;
                        end
                    end
                end else if (r_in.kind == KIND_ERROR) begin
                    n_phase = PH_ERROR;
                    n_err   = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out.phase         = r_phase;
                    n_out.state_changed = r_changed;
                    n_out.max_altitude  = r_max_alt;
                    n_out.velocity_used = (r_in.kind == KIND_SAMPLE) ? r_vel : 32'sd0;
                    n_out.launch_time   = r_evt[0];
                    n_out.apogee_time   = r_evt[1];
                    n_out.landed_time   = r_evt[2];
                    n_out.logging_on    = r_log;
                    n_out.radio_on      = r_radio;
                    n_out.error_flag    = r_err;
                    n_ovalid            = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_ready)
        else $error("ready while item in flight");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while waiting");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIV)
        else $error("divide result outside divide state");

endmodule

// ===== src/fpd_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fpd_pkg.
module fpd_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fpd_pkg::t_div_req i_req,
    output fpd_pkg::t_div_rsp o_rsp
);
    import fpd_pkg::*;

    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[DIV_BITS-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_cnt  = 6'(DIV_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_quo = {r_quo[DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[DIV_BITS-1]};
                n_quo = {r_quo[DIV_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0)
        else $error("divider busy with zero count");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the flight phase detector: drives sensor and command items, predicts each
// result with its own phase machine model, and compares field by field. Depends on fpd_pkg
// and flight_phase_detector_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fpd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_item i_item = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_item o_item;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    always #4 i_clk = ~i_clk;

    flight_phase_detector_top dut (.*);

    // predictor state
    logic signed [15:0] cf_launch_acc;
    logic [15:0]        cf_launch_hold;
    logic signed [31:0] cf_apogee_vel;
    logic [15:0]        cf_apogee_hold;
    logic signed [31:0] cf_landed_alt;
    logic [14:0]        cf_landed_acc;
    logic [15:0]        cf_landed_hold;
    t_phase             m_phase;
    logic signed [31:0] m_max_alt, m_prev_alt;
    logic [31:0]        m_last_t;
    logic [31:0]        m_hold_t [3];
    logic               m_hold_on [3];
    logic [31:0]        m_evt [3];
    logic               m_log, m_err;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int  errors = 0;
    int  gap_left = 0, burst_left = 0;
    int  stall_len = 0;
    int  stall_hold = 0;
    bit  stall_taken = 0;
    bit  drain_req = 0;
    int  idle_cycles = 0;

    function automatic bit hold_fires(int i, bit cond, logic [31:0] now, logic [31:0] hold);
        if (!cond) begin
            m_hold_on[i] = 0;
            return 0;
        end
        if (!m_hold_on[i]) begin
            m_hold_on[i] = 1;
            m_hold_t[i] = now;
            return 0;
        end
        if (now - m_hold_t[i] >= hold) begin
            m_hold_on[i] = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic t_out_item predict_phase(t_in_item it);
        t_out_item r;
        logic [31:0] dt;
        logic signed [31:0] vel;
        longint q;
        int d;
        bit chg;
        vel = 0;
        chg = 0;
        if (it.kind == KIND_SAMPLE) begin
            dt = it.time_ms - m_last_t;
            m_last_t = it.time_ms;
            if (it.altitude > m_max_alt) m_max_alt = it.altitude;
            vel = it.velocity;
            if (vel == 0 && dt != 0) begin
                q = ((longint'(it.altitude) - longint'(m_prev_alt)) * 1000)
                    / longint'({32'd0, dt});
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                vel = q[31:0];
            end
            case (m_phase)
                PH_ARMED: if (hold_fires(0, it.acceleration > cf_launch_acc, it.time_ms,
                                         {16'd0, cf_launch_hold})) begin
                    m_phase = PH_LAUNCH; m_evt[0] = it.time_ms; chg = 1;
                end
                PH_LAUNCH: if (hold_fires(1, vel < cf_apogee_vel, it.time_ms,
                                          {16'd0, cf_apogee_hold})) begin
                    m_phase = PH_APOGEE; m_evt[1] = it.time_ms; chg = 1;
                end
                PH_APOGEE: if (vel < -32'sd256) begin
                    m_phase = PH_DESCENT; chg = 1;
                end
                PH_DESCENT: begin
                    d = int'(it.acceleration) - 256;
                    if (d < 0) d = -d;
                    if (hold_fires(2, it.altitude < cf_landed_alt && d < int'(cf_landed_acc),
                                   it.time_ms, {16'd0, cf_landed_hold})) begin
                        m_phase = PH_LANDED; m_evt[2] = it.time_ms; chg = 1;
                    end
                end
                default: ;
            endcase
            m_prev_alt = it.altitude;
        end else if (it.kind == KIND_SET) begin
            if (it.new_phase <= PH_ERROR) begin
                m_phase = t_phase'(it.new_phase);
                if (it.new_phase == PH_ARMED) m_log = 1;
                else if (it.new_phase == PH_UNARMED) m_log = 0;
            end
        end else if (it.kind == KIND_ERROR) begin
            m_phase = PH_ERROR;
            m_err = 1;
        end
        r.phase = m_phase;
        r.state_changed = chg;
        r.max_altitude = m_max_alt;
        r.velocity_used = vel;
        r.launch_time = m_evt[0];
        r.apogee_time = m_evt[1];
        r.landed_time = m_evt[2];
        r.logging_on = m_log;
        r.radio_on = m_log;
        r.error_flag = m_err;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_results.push_back(predict_phase(i_item));
            void'(pending_items.pop_front());
        end
        if (i_valid && !o_ready) begin
        end else if (pending_items.size() == 0 || !i_rst_n || drain_req) begin
            i_valid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid <= 1'b0;
        end else begin
            i_item <= pending_items[0];
            i_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_item.phase !== e.phase) begin
                    $error("phase exp %0d got %0d", e.phase, o_item.phase); errors++; end
                if (o_item.state_changed !== e.state_changed) begin
                    $error("state_changed exp %0d got %0d", e.state_changed,
                           o_item.state_changed); errors++; end
                if (o_item.max_altitude !== e.max_altitude) begin
                    $error("max_altitude exp %0d got %0d", e.max_altitude,
                           o_item.max_altitude); errors++; end
                if (o_item.velocity_used !== e.velocity_used) begin
                    $error("velocity_used exp %0d got %0d", e.velocity_used,
                           o_item.velocity_used); errors++; end
                if (o_item.launch_time !== e.launch_time) begin
                    $error("launch_time exp %0d got %0d", e.launch_time,
                           o_item.launch_time); errors++; end
                if (o_item.apogee_time !== e.apogee_time) begin
                    $error("apogee_time exp %0d got %0d", e.apogee_time,
                           o_item.apogee_time); errors++; end
                if (o_item.landed_time !== e.landed_time) begin
                    $error("landed_time exp %0d got %0d", e.landed_time,
                           o_item.landed_time); errors++; end
                if (o_item.logging_on !== e.logging_on) begin
                    $error("logging_on exp %0d got %0d", e.logging_on,
                           o_item.logging_on); errors++; end
                if (o_item.radio_on !== e.radio_on) begin
                    $error("radio_on exp %0d got %0d", e.radio_on, o_item.radio_on);
                    errors++; end
                if (o_item.error_flag !== e.error_flag) begin
                    $error("error_flag exp %0d got %0d", e.error_flag,
                           o_item.error_flag); errors++; end
            end
        end
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            i_ready <= 1'b0;
        end else if (stall_len != 0 && !stall_taken) begin
            stall_hold <= stall_len;
            stall_taken <= 1'b1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n && ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("flight_phase_detector_top: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_LAUNCH_ACC:  cf_launch_acc = val[15:0];
            REG_LAUNCH_HOLD: cf_launch_hold = val[15:0];
            REG_APOGEE_VEL:  cf_apogee_vel = val;
            REG_APOGEE_HOLD: cf_apogee_hold = val[15:0];
            REG_LANDED_ALT:  cf_landed_alt = val;
            REG_LANDED_ACC:  cf_landed_acc = val[14:0];
            default:         cf_landed_hold = val[15:0];
        endcase
    endtask

    function automatic t_in_item mk(logic [1:0] k, logic [31:0] t, logic [31:0] a,
                                    logic [15:0] acc, logic [31:0] v, logic [2:0] np);
        t_in_item it;
        it.kind = k; it.time_ms = t; it.altitude = a;
        it.acceleration = acc; it.velocity = v; it.new_phase = np;
        return it;
    endfunction

    // one flight: arm, climb, descend, land, random content
    task automatic push_flight(inout logic [31:0] t);
        int n;
        logic [31:0] alt;
        alt = $urandom_range(0, 2000);
        pending_items.push_back(mk(KIND_SET, $urandom, $urandom, 16'($urandom), $urandom,
                                   PH_ARMED));
        n = $urandom_range(2, 8);
        repeat (n) begin
            t += $urandom_range(0, 80);
            alt += $urandom_range(0, 3000);
            pending_items.push_back(mk(KIND_SAMPLE, t, alt, 16'($urandom_range(300, 3000)),
                                       ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9000),
                                       3'($urandom)));
        end
        n = $urandom_range(2, 8);
        repeat (n) begin
            t += $urandom_range(0, 80);
            alt -= $urandom_range(0, 3000);
            pending_items.push_back(mk(KIND_SAMPLE, t, alt, 16'($urandom),
                                       ($urandom_range(0, 1) == 0) ? 0 : -$urandom_range(1, 9000),
                                       3'($urandom)));
        end
        n = $urandom_range(2, 10);
        repeat (n) begin
            t += $urandom_range(0, 900);
            alt = $urandom_range(0, 9000);
            pending_items.push_back(mk(KIND_SAMPLE, t, alt,
                                       16'(256 + $urandom_range(0, 40) - 20),
                                       ($urandom_range(0, 1) == 0) ? 0 : $urandom,
                                       3'($urandom)));
        end
    endtask

    task automatic push_noise(inout logic [31:0] t);
        logic [1:0] k;
        k = 2'($urandom_range(0, 3));
        t += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
        pending_items.push_back(mk(k, t, $urandom, 16'($urandom),
                                   ($urandom_range(0, 1) == 0) ? 0 : $urandom, 3'($urandom)));
    endtask

    initial begin
        logic [31:0] t;
        cf_launch_acc = 512; cf_launch_hold = 100; cf_apogee_vel = 0; cf_apogee_hold = 100;
        cf_landed_alt = 7680; cf_landed_acc = 51; cf_landed_hold = 2000;
        m_phase = PH_UNARMED; m_max_alt = 0; m_prev_alt = 0; m_last_t = 0;
        for (int i = 0; i < 3; i++) begin
            m_hold_t[i] = 0; m_hold_on[i] = 0; m_evt[i] = 0;
        end
        m_log = 0; m_err = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_LAUNCH_ACC, 32'h0000_8000);
        write_reg(REG_LAUNCH_HOLD, 0);
        write_reg(REG_APOGEE_VEL, 32'h7FFF_FFFF);
        write_reg(REG_APOGEE_HOLD, 0);
        write_reg(REG_LANDED_ALT, 32'h7FFF_FFFF);
        write_reg(REG_LANDED_ACC, 32'h7FFF);
        write_reg(REG_LANDED_HOLD, 0);

        // directed: extremes, every kind and phase, unused codes, derive cases
        pending_items.push_back(mk(KIND_SAMPLE, 0, 32'h7FFF_FFFF, 16'h7FFF, 0, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 0, 32'h8000_0000, 16'h8000, 0, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 1, 32'h7FFF_FFFF, 16'h7FFF, 0,
                                   PH_CODE_UNUSED));
        pending_items.push_back(mk(KIND_SAMPLE, 3, 32'h8000_0000, 16'h8000, 0, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 32'hFFFF_FFFF, 5, 0, 32'h8000_0000, 0));
        pending_items.push_back(mk(KIND_SET, 32'hFFFF_FFFF, '1, '1, '1, PH_CODE_UNUSED));
        pending_items.push_back(mk(KIND_SET, 0, 0, 0, 0, PH_ARMED));
        pending_items.push_back(mk(KIND_SAMPLE, 10, 100, 16'h7FFF, 32'h7FFF_FFFF, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 10, 100, 16'h7FFF, 32'h7FFF_FFFF, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 20, 50, 0, -32'sd1000, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 20, 50, 0, -32'sd1000, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 30, 0, 0, -32'sd1000, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 40, 0, 256, 7, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 40, 0, 256, 7, 0));
        pending_items.push_back(mk(KIND_SAMPLE, 50, 0, 256, 7, 0));
        for (int p = PH_UNARMED; p <= PH_ERROR; p++)
            pending_items.push_back(mk(KIND_SET, 60, 0, 0, 0, p[2:0]));
        pending_items.push_back(mk(KIND_ERROR, 70, 0, 0, 0, 0));
        pending_items.push_back(mk(KIND_SPARE, 80, 0, 0, 0, 0));
        pending_items.push_back(mk(KIND_SET, 90, 0, 0, 0, PH_UNARMED));
        pending_items.push_back(mk(KIND_SAMPLE, 100, 0, 16'h7FFF, 0, 0));
        wait_drained();

        write_reg(REG_LAUNCH_ACC, 32'h0000_7FFF);
        write_reg(REG_LAUNCH_HOLD, 32'hFFFF);
        write_reg(REG_APOGEE_VEL, 32'h8000_0000);
        write_reg(REG_APOGEE_HOLD, 32'hFFFF);
        write_reg(REG_LANDED_ALT, 32'h8000_0000);
        write_reg(REG_LANDED_ACC, 0);
        write_reg(REG_LANDED_HOLD, 32'hFFFF);
        t = 0;
        repeat (40) push_noise(t);
        // long receiver hold-off while items keep coming
        stall_len = 400;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_LAUNCH_ACC, $urandom_range(200, 800));
            write_reg(REG_LAUNCH_HOLD, $urandom_range(0, 150));
            write_reg(REG_APOGEE_VEL, $urandom_range(0, 400));
            write_reg(REG_APOGEE_HOLD, $urandom_range(0, 150));
            write_reg(REG_LANDED_ALT, $urandom_range(2000, 8000));
            write_reg(REG_LANDED_ACC, $urandom_range(10, 60));
            write_reg(REG_LANDED_HOLD, $urandom_range(0, 2000));
            repeat (18) begin
                if ($urandom_range(0, 3) == 0) push_noise(t);
                else push_flight(t);
            end
            // pause the sender until everything has come back
            drain_req = 1;
            while (expected_results.size() != 0 || i_valid) @(posedge i_clk);
            drain_req = 0;
            wait_drained();
        end
        wait_drained();
        if (errors == 0)
            $display("flight_phase_detector_top: match");
        else
            $display("flight_phase_detector_top: mismatch");
        $finish;
    end
endmodule
